// ===== rtl/hssc_pkg.sv =====
// ----------------------------------------------------------------------------
// hssc_pkg
// Shared types, constants and lookup functions of the Hall six-step
// commutator: hall sequence tables, sector offsets and step timer words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hssc_pkg;

	// angle units: full turn is 65536
	localparam int unsigned TURN       = 65536;
	localparam int unsigned SECT60     = TURN / 6;
	localparam int unsigned SECT120    = TURN / 3;
	localparam int          HALF_SECT  = SECT60 / 2;

	// sector boundaries on the signed angle
	localparam logic signed [15:0] BND_1 = 16'(HALF_SECT);
	localparam logic signed [15:0] BND_2 = 16'(SECT60 + HALF_SECT);
	localparam logic signed [15:0] BND_3 = 16'(SECT120 + HALF_SECT);
	localparam logic signed [15:0] BND_4 = -16'(SECT120 + HALF_SECT);
	localparam logic signed [15:0] BND_5 = -16'(SECT60 + HALF_SECT);
	localparam logic signed [15:0] BND_6 = -16'(HALF_SECT);

	// sector offsets
	localparam logic [15:0] OFF_0    = 16'd0;
	localparam logic [15:0] OFF_P60  = 16'(SECT60);
	localparam logic [15:0] OFF_P120 = 16'(SECT120);
	localparam logic [15:0] OFF_P180 = 16'(SECT120 + SECT60);
	localparam logic [15:0] OFF_M60  = 16'(TURN - SECT60);
	localparam logic [15:0] OFF_M120 = 16'(TURN - SECT120);

	// direction codes
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_REV  = 2'b11;

	// invalid hall codes
	localparam logic [2:0] HALL_LOW  = 3'd0;
	localparam logic [2:0] HALL_HIGH = 3'd7;

	// commutation steps
	localparam logic [2:0] STEP_NONE = 3'd0;
	localparam logic [2:0] STEP_1    = 3'd1;
	localparam logic [2:0] STEP_2    = 3'd2;
	localparam logic [2:0] STEP_3    = 3'd3;
	localparam logic [2:0] STEP_4    = 3'd4;
	localparam logic [2:0] STEP_5    = 3'd5;
	localparam logic [2:0] STEP_6    = 3'd6;

	// configuration register index
	localparam logic REG_PHASE_OFFSET = 1'b0;

	// rotor tracking state seen by the sector decoder
	typedef struct packed {
		logic [1:0]  dir;
		logic [15:0] angle;
	} track_t;

	// step decode result
	typedef struct packed {
		logic [2:0]  step;
		logic        commutate;
		logic [15:0] enable_word;
		logic [15:0] mode_word_low;
		logic [15:0] mode_word_high;
	} sector_t;

	// code that precedes a given code in forward rotation
	function automatic logic [2:0] fwd_pred(input logic [2:0] code);
		logic [2:0] r;
		unique case (code)
			3'd1:    r = 3'd3;
			3'd2:    r = 3'd6;
			3'd3:    r = 3'd2;
			3'd4:    r = 3'd5;
			3'd5:    r = 3'd1;
			3'd6:    r = 3'd4;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// code that precedes a given code in reverse rotation
	function automatic logic [2:0] rev_pred(input logic [2:0] code);
		logic [2:0] r;
		unique case (code)
			3'd1:    r = 3'd5;
			3'd2:    r = 3'd3;
			3'd3:    r = 3'd1;
			3'd4:    r = 3'd6;
			3'd5:    r = 3'd4;
			3'd6:    r = 3'd2;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	// sector offset on forward entry
	function automatic logic [15:0] fwd_off(input logic [2:0] code);
		logic [15:0] r;
		unique case (code)
			3'd2:    r = OFF_M120;
			3'd3:    r = OFF_M60;
			3'd4:    r = OFF_P120;
			3'd5:    r = OFF_P60;
			3'd6:    r = OFF_P180;
			default: r = OFF_0;
		endcase
		return r;
	endfunction

	// sector offset on reverse entry
	function automatic logic [15:0] rev_off(input logic [2:0] code);
		logic [15:0] r;
		unique case (code)
			3'd1:    r = OFF_P60;
			3'd2:    r = OFF_M60;
			3'd4:    r = OFF_P180;
			3'd5:    r = OFF_P120;
			3'd6:    r = OFF_M120;
			default: r = OFF_0;
		endcase
		return r;
	endfunction

	// output-enable word per step
	function automatic logic [15:0] en_word(input logic [2:0] step);
		logic [15:0] r;
		unique case (step)
			STEP_1, STEP_4: r = 16'h1505;
			STEP_2, STEP_5: r = 16'h1550;
			STEP_3, STEP_6: r = 16'h1055;
			default:        r = 16'h0000;
		endcase
		return r;
	endfunction

	// mode word a per step
	function automatic logic [15:0] mlo_word(input logic [2:0] step);
		logic [15:0] r;
		unique case (step)
			STEP_1:  r = 16'h0868;
			STEP_2:  r = 16'h6808;
			STEP_3:  r = 16'h6848;
			STEP_4:  r = 16'h0848;
			STEP_5:  r = 16'h4808;
			STEP_6:  r = 16'h4868;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

	// mode word b per step
	function automatic logic [15:0] mhi_word(input logic [2:0] step);
		logic [15:0] r;
		unique case (step)
			STEP_1, STEP_2: r = 16'h6848;
			STEP_3, STEP_6: r = 16'h6808;
			STEP_4, STEP_5: r = 16'h6868;
			default:        r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/hssc_tracker.sv =====
// ----------------------------------------------------------------------------
// hssc_tracker
// Holds the last hall code, direction and rotor angle; on each update it
// detects an adjacent hall transition and sets direction and angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hssc_tracker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  logic [2:0]          hall,
	input  logic [15:0]         phase_offset,
	output hssc_pkg::track_t    trk_next
);

	logic [2:0]  hall_now_q;
	logic [1:0]  dir_q;
	logic [15:0] angle_q;
	logic        code_ok;
	logic        is_fwd;
	logic        is_rev;

	// transition detect against the previous code
	always_comb begin
		code_ok = (hall != hssc_pkg::HALL_LOW) && (hall != hssc_pkg::HALL_HIGH);
		is_fwd  = code_ok && (hall_now_q == hssc_pkg::fwd_pred(hall));
		is_rev  = code_ok && !is_fwd && (hall_now_q == hssc_pkg::rev_pred(hall));
	end

	// next direction and angle for this sample
	always_comb begin
		priority if (is_fwd) begin
			trk_next.dir   = hssc_pkg::DIR_FWD;
			trk_next.angle = phase_offset + hssc_pkg::fwd_off(hall);
		end else if (is_rev) begin
			trk_next.dir   = hssc_pkg::DIR_REV;
			trk_next.angle = phase_offset + hssc_pkg::rev_off(hall);
		end else begin
			trk_next.dir   = dir_q;
			trk_next.angle = angle_q;
		end
	end

	// tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hall_now_q <= 3'd0;
			dir_q      <= hssc_pkg::DIR_NONE;
			angle_q    <= 16'd0;
		end else if (upd) begin
			hall_now_q <= hall;
			dir_q      <= trk_next.dir;
			angle_q    <= trk_next.angle;
		end
	end

endmodule

// ===== rtl/hssc_sector.sv =====
// ----------------------------------------------------------------------------
// hssc_sector
// Decodes the rotor angle into a commutation step, looks up the step's
// timer words and flags a change against the applied step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hssc_sector (
	input  logic [15:0]         angle,
	input  logic [2:0]          active_step,
	output hssc_pkg::sector_t   sec
);

	logic signed [15:0] a;
	logic [2:0]         step;

	// sector decode on the signed angle
	always_comb begin
		a = $signed(angle);
		priority if (a >= hssc_pkg::BND_1 && a < hssc_pkg::BND_2) begin
			step = hssc_pkg::STEP_1;
		end else if (a >= hssc_pkg::BND_2 && a < hssc_pkg::BND_3) begin
			step = hssc_pkg::STEP_2;
		end else if (a >= hssc_pkg::BND_3 || a < hssc_pkg::BND_4) begin
			step = hssc_pkg::STEP_3;
		end else if (a < hssc_pkg::BND_5) begin
			step = hssc_pkg::STEP_4;
		end else if (a < hssc_pkg::BND_6) begin
			step = hssc_pkg::STEP_5;
		end else begin
			step = hssc_pkg::STEP_6;
		end
	end

	// step words and change flag
	always_comb begin
		sec.step           = step;
		sec.commutate      = (step != active_step);
		sec.enable_word    = hssc_pkg::en_word(step);
		sec.mode_word_low  = hssc_pkg::mlo_word(step);
		sec.mode_word_high = hssc_pkg::mhi_word(step);
	end

endmodule

// ===== rtl/hall_six_step_commutator_unit.sv =====
// ----------------------------------------------------------------------------
// hall_six_step_commutator_unit
// Each accepted hall sample gives exactly one result, valid on the output
// once it has passed the input and output registers; a stalled output holds
// it longer. A new sample may be accepted every cycle unless the output is
// stalled. From the input register one pass of logic (transition detect,
// offset add, sector compare, word lookup) writes tracking state and output
// register, closing the state loop in it. An adjacent hall transition
// sets direction and angle = phase_offset + sector offset; the angle picks
// step 1..6, and commutate is set when that step differs from the one
// applied before (always on the first sample after reset). phase_offset
// sits at APB address 0 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hall_six_step_commutator_unit (
	input  logic        clk,
	input  logic        arst_n,
	// apb configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// hall sample input
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] hall_code, [7:3] zero
	// commutation result output
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [2:0] step, [4:3] direction, [20:5] angle,
	                               // [21] commutate, [37:22] enable_word,
	                               // [53:38] mode_word_low, [69:54] mode_word_high,
	                               // [71:70] zero
);

	logic [15:0]        phase_offset_q;
	logic               valid_s1;
	logic [2:0]         hall_s1;
	logic               out_valid_q;
	logic [2:0]         active_step_q;
	logic               out_free;
	logic               move_s1;
	logic               cfg_wr;
	hssc_pkg::track_t   trk_next;
	hssc_pkg::sector_t  sec;
	hssc_pkg::track_t   trk_s2;
	hssc_pkg::sector_t  sec_s2;

	// apb register access
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
	                && (paddr[2] == hssc_pkg::REG_PHASE_OFFSET);
	assign prdata = (paddr[2] == hssc_pkg::REG_PHASE_OFFSET) ?
	                {16'd0, phase_offset_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_offset_q <= 16'd0;
		end else if (cfg_wr) begin
			phase_offset_q <= pwdata[15:0];
		end
	end

	// handshake: the output register frees when empty or taken
	assign out_free = !out_valid_q || m_tready;
	assign move_s1  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			hall_s1 <= s_tdata[2:0];
		end
	end

	// rotor tracking
	hssc_tracker u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.upd          (move_s1),
		.hall         (hall_s1),
		.phase_offset (phase_offset_q),
		.trk_next     (trk_next)
	);

	// step decode
	hssc_sector u_sector (
		.angle        (trk_next.angle),
		.active_step  (active_step_q),
		.sec          (sec)
	);

	// applied step and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			active_step_q <= hssc_pkg::STEP_NONE;
		end else begin
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
			if (move_s1) begin
				active_step_q <= sec.step;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (move_s1) begin
			trk_s2 <= trk_next;
			sec_s2 <= sec;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, sec_s2.mode_word_high, sec_s2.mode_word_low,
	                   sec_s2.enable_word, sec_s2.commutate, trk_s2.angle,
	                   trk_s2.dir, sec_s2.step};

endmodule
